// File: src/safk_pkg.sv
// Package for the serial arm forward kinematics block: types, constants, scratch map, helpers.
// Used by safk_cordic, safk_dp, safk_ctrl and serial_arm_forward_kinematics.
package safk_pkg;

	localparam int JOINTS_DEF       = 6;
	localparam int CORDIC_STEPS_DEF = 24;
	localparam int MODEL_WORDS      = 15;
	localparam int JCOLS            = 6;
	localparam int AW               = 8;
	localparam int RAM_DEPTH        = 256;
	localparam int ACC_W            = 35;
	localparam int CZ_W             = 34;
	localparam int STEP_W           = 5;
	localparam int JNT_W            = 3;

	localparam logic signed [31:0]     Q_ONE      = 32'sd16777216;
	localparam logic signed [CZ_W-1:0] C_PI       = 34'sd52707179;
	localparam logic signed [CZ_W-1:0] C_TWO_PI   = 34'sd105414357;
	localparam logic signed [CZ_W-1:0] C_HALF_PI  = 34'sd26353589;
	localparam logic signed [CZ_W-1:0] C_GAIN     = 34'sd10188014;

	// scratch map above the model words
	localparam logic [AW-1:0] A_S   = 8'd128;
	localparam logic [AW-1:0] A_C   = 8'd129;
	localparam logic [AW-1:0] A_OC  = 8'd130;
	localparam logic [AW-1:0] A_P   = 8'd131;
	localparam logic [AW-1:0] A_TJ  = 8'd140;
	localparam logic [AW-1:0] A_LK  = 8'd149;
	localparam logic [AW-1:0] A_TOT = 8'd158;
	localparam logic [AW-1:0] A_NT  = 8'd170;
	localparam logic [AW-1:0] A_ZC  = 8'd182;
	localparam logic [AW-1:0] A_PJ  = 8'd200;
	localparam logic [AW-1:0] A_D   = 8'd218;
	localparam logic [AW-1:0] A_JAC = 8'd221;

	typedef enum logic [1:0] {FN_WORD, FN_ANGLE, FN_POSE, FN_JAC} func_code_t;

	typedef enum logic [3:0] {
		OP_LDZ, OP_LD1, OP_LDA, OP_ADD, OP_MAC, OP_EMIT, OP_EMITZ, OP_WRS, OP_WRC
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE, PH_INIT, PH_CSTART, PH_CWAIT, PH_SC, PH_OC, PH_PROD, PH_TJ, PH_LK,
		PH_TOT, PH_COPY, PH_SAVE, PH_EMITP, PH_JC, PH_EMITJ
	} phase_t;

	typedef enum logic [1:0] {CS_IDLE, CS_WRAP, CS_ROT} cord_state_t;

	typedef struct packed {
		op_t           op;
		logic          neg;
		logic          clr;
		logic          wr;
		logic [AW-1:0] sa;
		logic [AW-1:0] sb;
		logic [AW-1:0] dst;
		logic          kind;
		logic [2:0]    row;
		logic [2:0]    col;
		logic          last;
	} uop_t;

	typedef struct packed {
		logic             go;
		uop_t             uop;
		logic             cord_start;
		logic [JNT_W-1:0] joint;
		logic             mw;
		logic             aw;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
		logic cord_done;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [CZ_W-1:0] atan_q(input logic [STEP_W-1:0] i);
		case (i)
			5'd0:  return 34'sd13176795;
			5'd1:  return 34'sd7778716;
			5'd2:  return 34'sd4110060;
			5'd3:  return 34'sd2086331;
			5'd4:  return 34'sd1047214;
			5'd5:  return 34'sd524117;
			5'd6:  return 34'sd262123;
			5'd7:  return 34'sd131069;
			5'd8:  return 34'sd65536;
			5'd9:  return 34'sd32768;
			5'd10: return 34'sd16384;
			5'd11: return 34'sd8192;
			5'd12: return 34'sd4096;
			5'd13: return 34'sd2048;
			5'd14: return 34'sd1024;
			5'd15: return 34'sd512;
			5'd16: return 34'sd256;
			5'd17: return 34'sd128;
			5'd18: return 34'sd64;
			5'd19: return 34'sd32;
			5'd20: return 34'sd16;
			5'd21: return 34'sd8;
			5'd22: return 34'sd4;
			5'd23: return 34'sd2;
			5'd24: return 34'sd1;
			default: return '0;
		endcase
	endfunction

	function automatic logic [AW-1:0] nx3(input logic [AW-1:0] m);
		return (m == 8'd2) ? 8'd0 : m + 8'd1;
	endfunction

endpackage

// File: src/serial_arm_forward_kinematics.sv
// Top level of the serial arm forward kinematics block.
// Depends on safk_pkg, safk_ctrl and safk_dp (with safk_cordic).
//
// Input stream (s_*): one beat is a model word write (func 0), a joint angle
// write (func 1), a pose computation (func 2) or pose plus Jacobian (func 3).
// Writes give no output; writes to joints or elements out
// of range are dropped.
// Output stream (m_*): twelve pose beats (rows 0-2, columns 0-3), then for
// func 3 thirty-six Jacobian beats (rows 0-5, columns 0-5); tlast marks the
// final beat of the computation.
// Every arithmetic step is one operation through a shared 32x32 multiplier
// and accumulator, with operands in a 256-word scratch RAM. Per joint:
// 115 operations plus the CORDIC, which wraps the angle into range and then
// runs CORDIC_STEPS rotation steps. One computation is in progress at a
// time; the next beat is taken in the cycle after the last result is issued,
// before that result reaches the output register.
// Reset clears the joint angles and all control; model words must be written
// before a computation. A stalled receiver holds the sequencer at the next emit.
module serial_arm_forward_kinematics #(
	parameter int JOINTS       = safk_pkg::JOINTS_DEF,
	parameter int CORDIC_STEPS = safk_pkg::CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // joint[2:0], element[6:3], value[38:7], zero[39]
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // row[2:0], col[5:3], entry[37:6], zero[39:38]
	output logic        m_tuser,  // kind
	output logic        m_tlast
);
	import safk_pkg::*;

	cmd_t               cmd;
	sts_t               sts;
	logic               fire;
	logic [2:0]         o_row, o_col;
	logic signed [31:0] o_entry;

	assign fire = s_tvalid && s_tready;

	safk_ctrl #(.JOINTS(JOINTS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fire),
		.in_ready (s_tready),
		.func     (s_tuser),
		.joint    (s_tdata[2:0]),
		.element  (s_tdata[6:3]),
		.cmd      (cmd),
		.sts      (sts)
	);

	safk_dp #(.JOINTS(JOINTS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.joint     (s_tdata[2:0]),
		.element   (s_tdata[6:3]),
		.value     (s_tdata[38:7]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_row   (o_row),
		.out_col   (o_col),
		.out_entry (o_entry),
		.out_last  (m_tlast)
	);

	assign m_tdata = {2'b00, o_entry, o_col, o_row};

endmodule

// File: src/safk_cordic.sv
// Sine/cosine unit: iterative angle wrap, quadrant fold, one CORDIC rotation step per cycle.
// Depends on safk_pkg.
module safk_cordic #(
	parameter int CORDIC_STEPS = safk_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] angle,
	output logic               done,
	output logic signed [31:0] sin_val,
	output logic signed [31:0] cos_val
);
	import safk_pkg::*;

	cord_state_t             state_q, state_d;
	logic signed [CZ_W-1:0]  z_q, z_d, x_q, x_d, y_q, y_d, xs, ys, xf, yf;
	logic [STEP_W-1:0]       i_q, i_d;
	logic                    neg_q, neg_d, fin, done_q;
	logic signed [31:0]      sin_q, cos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		z_q   <= z_d;
		x_q   <= x_d;
		y_q   <= y_d;
		i_q   <= i_d;
		neg_q <= neg_d;
		if (fin) begin
			sin_q <= sat32(64'(yf));
			cos_q <= sat32(64'(xf));
		end
	end

	always_comb begin
		state_d = state_q;
		z_d     = z_q;
		x_d     = x_q;
		y_d     = y_q;
		i_d     = i_q;
		neg_d   = neg_q;
		fin     = 1'b0;
		xs      = x_q >>> i_q;
		ys      = y_q >>> i_q;
		case (state_q)
			CS_IDLE: begin
				if (start) begin
					z_d     = CZ_W'(angle);
					neg_d   = 1'b0;
					state_d = CS_WRAP;
				end
			end
			CS_WRAP: begin
				if (z_q > C_PI) begin
					z_d = z_q - C_TWO_PI;
				end else if (z_q < -C_PI) begin
					z_d = z_q + C_TWO_PI;
				end else begin
					x_d     = C_GAIN;
					y_d     = '0;
					i_d     = '0;
					state_d = CS_ROT;
					if (z_q > C_HALF_PI) begin
						z_d   = z_q - C_PI;
						neg_d = 1'b1;
					end else if (z_q < -C_HALF_PI) begin
						z_d   = z_q + C_PI;
						neg_d = 1'b1;
					end
				end
			end
			CS_ROT: begin
				if (z_q >= 0) begin
					x_d = x_q - ys;
					y_d = y_q + xs;
					z_d = z_q - atan_q(i_q);
				end else begin
					x_d = x_q + ys;
					y_d = y_q - xs;
					z_d = z_q + atan_q(i_q);
				end
				i_d = i_q + 1'b1;
				if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
					fin     = 1'b1;
					state_d = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
		xf = neg_q ? -x_d : x_d;
		yf = neg_q ? -y_d : y_d;
	end

	assign done    = done_q;
	assign sin_val = sin_q;
	assign cos_val = cos_q;

endmodule

// File: src/safk_dp.sv
// Datapath: scratch RAM with model words, joint angles, shared multiplier, accumulator,
// CORDIC unit and the output register. Depends on safk_pkg and safk_cordic.
module safk_dp #(
	parameter int JOINTS       = safk_pkg::JOINTS_DEF,
	parameter int CORDIC_STEPS = safk_pkg::CORDIC_STEPS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  safk_pkg::cmd_t            cmd,
	output safk_pkg::sts_t            sts,
	input  logic [2:0]                joint,
	input  logic [3:0]                element,
	input  logic signed [31:0]        value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      out_kind,
	output logic [2:0]                out_row,
	output logic [2:0]                out_col,
	output logic signed [31:0]        out_entry,
	output logic                      out_last
);
	import safk_pkg::*;

	localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	logic signed [31:0]      ram_q [RAM_DEPTH];
	logic signed [31:0]      ang_q [JOINTS];
	logic signed [31:0]      a_s1, b_s1, a_s2, q, wdata, s_val, c_val;
	logic signed [63:0]      prod_s2;
	logic                    v_s1, v_s2;
	uop_t                    uop_s1, uop_s2;
	logic signed [ACC_W-1:0] acc_q, acc_d, base, a_ext, q_ext;
	logic                    we, st_emit, cdone;
	logic [AW-1:0]           waddr;
	logic                    ov_q, okind_q, olast_q;
	logic [2:0]              orow_q, ocol_q;
	logic signed [31:0]      oent_q;

	safk_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.cord_start),
		.angle   (ang_q[cmd.joint[JW-1:0]]),
		.done    (cdone),
		.sin_val (s_val),
		.cos_val (c_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < JOINTS; i++)
				ang_q[i] <= '0;
		end else if (cmd.aw) begin
			ang_q[joint[JW-1:0]] <= value;
		end
	end

	always_comb begin
		q     = sat32(prod_s2 >>> 24);
		a_ext = ACC_W'(a_s2);
		q_ext = ACC_W'(q);
		base  = uop_s2.clr ? '0 : acc_q;
		case (uop_s2.op)
			OP_LDZ:  acc_d = '0;
			OP_LD1:  acc_d = ACC_W'(Q_ONE);
			OP_LDA:  acc_d = uop_s2.neg ? -a_ext : a_ext;
			OP_ADD:  acc_d = acc_q + (uop_s2.neg ? -a_ext : a_ext);
			OP_MAC:  acc_d = base + (uop_s2.neg ? -q_ext : q_ext);
			default: acc_d = acc_q;
		endcase
		case (uop_s2.op)
			OP_WRS:  wdata = s_val;
			OP_WRC:  wdata = c_val;
			default: wdata = sat32(64'(acc_d));
		endcase
		st_emit = v_s2 && (uop_s2.op == OP_EMIT || uop_s2.op == OP_EMITZ);
		if (cmd.mw) begin
			we    = 1'b1;
			waddr = AW'(joint) * 8'd15 + AW'(element);
		end else begin
			we    = v_s2 && uop_s2.wr;
			waddr = uop_s2.dst;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			ram_q[waddr] <= cmd.mw ? value : wdata;
		a_s1 <= ram_q[cmd.uop.sa];
		b_s1 <= ram_q[cmd.uop.sb];
	end

	always_ff @(posedge clk) begin
		uop_s1  <= cmd.uop;
		uop_s2  <= uop_s1;
		a_s2    <= a_s1;
		prod_s2 <= 64'(a_s1) * 64'(b_s1);
		if (v_s2)
			acc_q <= acc_d;
		if (st_emit) begin
			okind_q <= uop_s2.kind;
			orow_q  <= uop_s2.row;
			ocol_q  <= uop_s2.col;
			olast_q <= uop_s2.last;
			oent_q  <= (uop_s2.op == OP_EMIT) ? a_s2 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			v_s1 <= cmd.go;
			v_s2 <= v_s1;
			if (st_emit)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	assign sts.out_busy  = ov_q;
	assign sts.cord_done = cdone;
	assign out_valid     = ov_q;
	assign out_kind      = okind_q;
	assign out_row       = orow_q;
	assign out_col       = ocol_q;
	assign out_entry     = oent_q;
	assign out_last      = olast_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		st_emit |-> (!ov_q || out_ready))
		else $error("result beat overwritten before it was taken");
	a_no_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mw |-> !(v_s2 && uop_s2.wr))
		else $error("model write collides with write-back");
	a_issue_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> (!v_s1 && !v_s2))
		else $error("operation issued while another is in flight");
`endif

endmodule

// File: src/safk_ctrl.sv
// Sequencer: walks the kinematics schedule and issues one datapath operation at a time.
// Depends on safk_pkg.
module safk_ctrl #(
	parameter int JOINTS = safk_pkg::JOINTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     func,
	input  logic [2:0]     joint,
	input  logic [3:0]     element,
	output safk_pkg::cmd_t cmd,
	input  safk_pkg::sts_t sts
);
	import safk_pkg::*;

	localparam int NCOL = (JOINTS < JCOLS) ? JOINTS : JCOLS;

	phase_t           phase_q, phase_d, nxt;
	logic [2:0]       r_q, r_d, c_q, c_d, rmax, cmax;
	logic [1:0]       k_q, k_d, kmax, wait_q, wait_d;
	logic [JNT_W-1:0] j_q, j_d;
	logic             jac_q, jac_d, is_emit, issue, ph_end;
	logic [AW-1:0]    r8, c8, k8, j8, mb, m8, ma, mc;
	uop_t             uop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
			j_q     <= '0;
			wait_q  <= '0;
			jac_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			r_q     <= r_d;
			c_q     <= c_d;
			k_q     <= k_d;
			j_q     <= j_d;
			wait_q  <= wait_d;
			jac_q   <= jac_d;
		end
	end

	// operation decode for the current phase and loop indices
	always_comb begin
		r8  = AW'(r_q);
		c8  = AW'(c_q);
		k8  = AW'(k_q);
		j8  = AW'(j_q);
		mb  = j8 * 8'd15;
		m8  = c8 - 8'd3;
		ma  = nx3(m8);
		mc  = nx3(ma);
		uop = '0;
		rmax = '0;
		cmax = '0;
		kmax = '0;
		is_emit = 1'b0;
		nxt = PH_IDLE;
		case (phase_q)
			PH_INIT: begin
				rmax = 3'd2; cmax = 3'd3; nxt = PH_CSTART;
				uop.op  = (r_q == c_q) ? OP_LD1 : OP_LDZ;
				uop.wr  = 1'b1;
				uop.dst = A_TOT + r8 * 8'd4 + c8;
			end
			PH_SC: begin
				cmax = 3'd1; nxt = PH_OC;
				uop.op  = (c_q == 3'd0) ? OP_WRS : OP_WRC;
				uop.wr  = 1'b1;
				uop.dst = (c_q == 3'd0) ? A_S : A_C;
			end
			PH_OC: begin
				kmax = 2'd1; nxt = PH_PROD;
				uop.op  = (k_q == 2'd0) ? OP_LD1 : OP_ADD;
				uop.neg = 1'b1;
				uop.sa  = A_C;
				uop.wr  = (k_q == 2'd1);
				uop.dst = A_OC;
			end
			PH_PROD: begin
				rmax = 3'd2; cmax = 3'd2; nxt = PH_TJ;
				uop.op  = OP_MAC;
				uop.clr = 1'b1;
				uop.sa  = mb + 8'd12 + r8;
				uop.sb  = mb + 8'd12 + c8;
				uop.wr  = 1'b1;
				uop.dst = A_P + r8 * 8'd3 + c8;
			end
			PH_TJ: begin
				rmax = 3'd2; cmax = 3'd2; kmax = 2'd1; nxt = PH_LK;
				uop.dst = A_TJ + r8 * 8'd3 + c8;
				uop.wr  = (k_q == 2'd1);
				if (k_q == 2'd0) begin
					uop.op  = (r_q == c_q) ? OP_LDA : OP_MAC;
					uop.clr = 1'b1;
					uop.sa  = (r_q == c_q) ? A_C : A_P + r8 * 8'd3 + c8;
					uop.sb  = A_OC;
				end else if (r_q == c_q) begin
					uop.op = OP_MAC;
					uop.sa = A_P + r8 * 8'd3 + c8;
					uop.sb = A_OC;
				end else begin
					uop.op  = OP_MAC;
					uop.neg = (r_q == 3'd0 && c_q == 3'd1) || (r_q == 3'd1 && c_q == 3'd2) ||
					          (r_q == 3'd2 && c_q == 3'd0);
					uop.sa  = mb + 8'd12 + (8'd3 - r8 - c8);
					uop.sb  = A_S;
				end
			end
			PH_LK: begin
				rmax = 3'd2; cmax = 3'd2; kmax = 2'd2; nxt = PH_TOT;
				uop.op  = OP_MAC;
				uop.clr = (k_q == 2'd0);
				uop.sa  = mb + r8 * 8'd3 + k8;
				uop.sb  = A_TJ + k8 * 8'd3 + c8;
				uop.wr  = (k_q == 2'd2);
				uop.dst = A_LK + r8 * 8'd3 + c8;
			end
			PH_TOT: begin
				rmax = 3'd2; cmax = 3'd3; nxt = PH_COPY;
				kmax = (c_q == 3'd3) ? 2'd3 : 2'd2;
				uop.dst = A_NT + r8 * 8'd4 + c8;
				uop.clr = (k_q == 2'd0);
				uop.sa  = A_TOT + r8 * 8'd4 + k8;
				if (c_q == 3'd3) begin
					uop.op = (k_q == 2'd3) ? OP_ADD : OP_MAC;
					uop.sb = mb + 8'd9 + k8;
					uop.wr = (k_q == 2'd3);
				end else begin
					uop.op = OP_MAC;
					uop.sb = A_LK + k8 * 8'd3 + c8;
					uop.wr = (k_q == 2'd2);
				end
			end
			PH_COPY: begin
				rmax = 3'd2; cmax = 3'd3; nxt = PH_SAVE;
				uop.op  = OP_LDA;
				uop.sa  = A_NT + r8 * 8'd4 + c8;
				uop.wr  = 1'b1;
				uop.dst = A_TOT + r8 * 8'd4 + c8;
			end
			PH_SAVE: begin
				rmax = 3'd2; cmax = 3'd1; nxt = PH_SAVE;
				uop.op  = OP_LDA;
				uop.sa  = A_TOT + r8 * 8'd4 + 8'd2 + c8;
				uop.wr  = 1'b1;
				uop.dst = ((c_q == 3'd0) ? A_ZC : A_PJ) + j8 * 8'd3 + r8;
			end
			PH_EMITP: begin
				rmax = 3'd2; cmax = 3'd3; is_emit = 1'b1;
				nxt = jac_q ? PH_JC : PH_IDLE;
				uop.op   = OP_EMIT;
				uop.sa   = A_TOT + r8 * 8'd4 + c8;
				uop.row  = r_q;
				uop.col  = c_q;
				uop.last = !jac_q && r_q == 3'd2 && c_q == 3'd3;
			end
			PH_JC: begin
				rmax = 3'(NCOL - 1); cmax = 3'd5; kmax = 2'd1; nxt = PH_EMITJ;
				uop.wr = (k_q == 2'd1);
				if (c_q < 3'd3) begin
					uop.op  = (k_q == 2'd0) ? OP_LDA : OP_ADD;
					uop.neg = (k_q == 2'd1);
					uop.sa  = (k_q == 2'd0) ? A_TOT + c8 * 8'd4 + 8'd3 : A_PJ + r8 * 8'd3 + c8;
					uop.dst = A_D + c8;
				end else begin
					uop.op  = OP_MAC;
					uop.clr = (k_q == 2'd0);
					uop.neg = (k_q == 2'd1);
					uop.sa  = A_ZC + r8 * 8'd3 + ((k_q == 2'd0) ? ma : mc);
					uop.sb  = A_D + ((k_q == 2'd0) ? mc : ma);
					uop.dst = A_JAC + m8 * 8'd6 + r8;
				end
			end
			PH_EMITJ: begin
				rmax = 3'd5; cmax = 3'd5; is_emit = 1'b1; nxt = PH_IDLE;
				uop.op   = ({1'b0, c_q} >= 4'(JOINTS)) ? OP_EMITZ : OP_EMIT;
				uop.sa   = (r_q < 3'd3) ? A_JAC + r8 * 8'd6 + c8 : A_ZC + c8 * 8'd3 + r8 - 8'd3;
				uop.kind = 1'b1;
				uop.row  = r_q;
				uop.col  = c_q;
				uop.last = (r_q == 3'd5 && c_q == 3'd5);
			end
			default: ;
		endcase
	end

	// next state, loop counters and command
	always_comb begin
		phase_d  = phase_q;
		r_d      = r_q;
		c_d      = c_q;
		k_d      = k_q;
		j_d      = j_q;
		jac_d    = jac_q;
		wait_d   = (wait_q != 2'd0) ? wait_q - 2'd1 : 2'd0;
		in_ready = (phase_q == PH_IDLE);
		cmd      = '0;
		cmd.uop  = uop;
		cmd.joint = j_q;
		issue    = 1'b0;
		ph_end   = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (in_valid) begin
					case (func)
						FN_WORD: cmd.mw = ({1'b0, joint} < 4'(JOINTS)) &&
						                  (element < 4'(MODEL_WORDS));
						FN_ANGLE: cmd.aw = ({1'b0, joint} < 4'(JOINTS));
						default: begin
							jac_d   = (func == FN_JAC);
							j_d     = '0;
							r_d     = '0;
							c_d     = '0;
							k_d     = '0;
							phase_d = PH_INIT;
						end
					endcase
				end
			end
			PH_CSTART: begin
				cmd.cord_start = 1'b1;
				phase_d        = PH_CWAIT;
			end
			PH_CWAIT: begin
				if (sts.cord_done)
					phase_d = PH_SC;
			end
			default: begin
				issue = (wait_q == 2'd0) && !(is_emit && sts.out_busy);
				if (issue) begin
					cmd.go = 1'b1;
					wait_d = 2'd2;
					if (k_q == kmax) begin
						k_d = '0;
						if (c_q == cmax) begin
							c_d = '0;
							if (r_q == rmax) begin
								r_d    = '0;
								ph_end = 1'b1;
							end else begin
								r_d = r_q + 3'd1;
							end
						end else begin
							c_d = c_q + 3'd1;
						end
					end else begin
						k_d = k_q + 2'd1;
					end
				end
				if (ph_end) begin
					if ((phase_q == PH_COPY && j_q >= 3'(JCOLS)) || phase_q == PH_SAVE) begin
						if (j_q == 3'(JOINTS - 1)) begin
							phase_d = PH_EMITP;
						end else begin
							j_d     = j_q + 3'd1;
							phase_d = PH_CSTART;
						end
					end else begin
						phase_d = nxt;
					end
				end
			end
		endcase
	end

endmodule

// File: tb/serial_arm_forward_kinematics_tb.sv
// Testbench for serial_arm_forward_kinematics: directed table then random beats,
// each result checked against an in-bench fixed-point kinematics predictor.
// Depends on safk_pkg and the serial_arm_forward_kinematics RTL.
module serial_arm_forward_kinematics_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NJ        = safk_pkg::JOINTS_DEF;
	localparam int NW        = safk_pkg::MODEL_WORDS;
	localparam int STEPS     = safk_pkg::CORDIC_STEPS_DEF;
	localparam int WDOG_LIM  = 20000;
	localparam int HOLD_CYC  = 4000;
	localparam longint QPI   = 52707179;
	localparam longint Q2PI  = 105414357;
	localparam longint QHPI  = 26353589;
	localparam longint QGAIN = 10188014;
	localparam int ONE       = safk_pkg::Q_ONE;

	typedef enum logic [1:0] {F_WORD, F_ANGLE, F_POSE, F_JAC} func_t;
	typedef enum logic {K_POSE, K_JAC} kind_t;

	typedef int mat_t [4][4];

	typedef struct {
		kind_t       kind;
		logic [2:0]  row;
		logic [2:0]  col;
		logic [31:0] entry;
		logic        last;
	} beat_t;

	typedef struct {
		func_t       func;
		logic [2:0]  joint;
		logic [3:0]  element;
		logic [31:0] value;
		bit          ident_z;
	} stim_t;

	const int atan_q24 [25] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
		262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
		32, 16, 8, 4, 2, 1};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	int    arm_words [NJ*NW];
	int    arm_angles [NJ];
	beat_t pending_beats [$];
	int    errors;
	int    s_idle;
	int    m_stall;
	bit    hold_go;
	int    hold_left;
	int    quiet_cyc;

	serial_arm_forward_kinematics i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int sat(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic int qmul(int a, int b);
		return sat((longint'(a) * longint'(b)) >>> 24);
	endfunction

	function automatic void sin_cos(int ang, output int s, output int c);
		longint z, x, y, nx;
		bit flip;
		z = ang;
		x = QGAIN;
		y = 0;
		flip = 1'b0;
		while (z > QPI) z -= Q2PI;
		while (z < -QPI) z += Q2PI;
		if (z > QHPI) begin
			z -= QPI;
			flip = 1'b1;
		end else if (z < -QHPI) begin
			z += QPI;
			flip = 1'b1;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z -= atan_q24[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z += atan_q24[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = sat(x);
		s = sat(y);
	endfunction

	function automatic mat_t mmul(mat_t a, mat_t b);
		mat_t t;
		longint acc;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				acc = 0;
				for (int k = 0; k < 4; k++)
					acc += qmul(a[i][k], b[k][j]);
				t[i][j] = sat(acc);
			end
		return t;
	endfunction

	function automatic mat_t link_xform(int j);
		mat_t to, tj;
		int b, ax, ay, az, s, c, oc;
		b  = j * NW;
		ax = arm_words[b+12];
		ay = arm_words[b+13];
		az = arm_words[b+14];
		for (int r = 0; r < 4; r++)
			for (int k = 0; k < 4; k++) begin
				to[r][k] = 0;
				tj[r][k] = 0;
			end
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++)
				to[r][k] = arm_words[b + r*3 + k];
			to[r][3] = arm_words[b + 9 + r];
		end
		to[3][3] = ONE;
		tj[3][3] = ONE;
		sin_cos(arm_angles[j], s, c);
		oc = sat(longint'(ONE) - c);
		tj[0][0] = sat(longint'(c) + qmul(qmul(ax, ax), oc));
		tj[0][1] = sat(longint'(qmul(qmul(ax, ay), oc)) - qmul(az, s));
		tj[0][2] = sat(longint'(qmul(qmul(ax, az), oc)) + qmul(ay, s));
		tj[1][0] = sat(longint'(qmul(qmul(ay, ax), oc)) + qmul(az, s));
		tj[1][1] = sat(longint'(c) + qmul(qmul(ay, ay), oc));
		tj[1][2] = sat(longint'(qmul(qmul(ay, az), oc)) - qmul(ax, s));
		tj[2][0] = sat(longint'(qmul(qmul(az, ax), oc)) - qmul(ay, s));
		tj[2][1] = sat(longint'(qmul(qmul(az, ay), oc)) + qmul(ax, s));
		tj[2][2] = sat(longint'(c) + qmul(qmul(az, az), oc));
		return mmul(to, tj);
	endfunction

	function automatic void push_beat(kind_t k, int r, int c, int v);
		beat_t b;
		b.kind  = k;
		b.row   = r[2:0];
		b.col   = c[2:0];
		b.entry = v;
		b.last  = 1'b0;
		pending_beats.push_back(b);
	endfunction

	// apply one accepted beat to the arm state and queue the entries it yields
	function automatic void predict_kinematics(stim_t st);
		mat_t tot;
		int zc [6][3];
		int pj [6][3];
		int d [3];
		int jac [6][6];
		if (st.func == F_WORD) begin
			if (st.joint < NJ && st.element < NW)
				arm_words[st.joint*NW + st.element] = st.value;
			return;
		end
		if (st.func == F_ANGLE) begin
			if (st.joint < NJ)
				arm_angles[st.joint] = st.value;
			return;
		end
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				tot[r][c] = (r == c) ? ONE : 0;
		for (int j = 0; j < 6; j++)
			for (int r = 0; r < 3; r++) begin
				zc[j][r] = 0;
				pj[j][r] = 0;
			end
		for (int j = 0; j < NJ; j++) begin
			tot = mmul(tot, link_xform(j));
			if (j < 6)
				for (int r = 0; r < 3; r++) begin
					zc[j][r] = tot[r][2];
					pj[j][r] = tot[r][3];
				end
		end
		// identity origins about z: translation stays zero, z row of z column is one
		if (st.ident_z) begin
			for (int r = 0; r < 3; r++)
				tot[r][3] = 0;
			tot[2][2] = ONE;
		end
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 4; c++)
				push_beat(K_POSE, r, c, tot[r][c]);
		if (st.func == F_JAC) begin
			for (int r = 0; r < 6; r++)
				for (int c = 0; c < 6; c++)
					jac[r][c] = 0;
			for (int j = 0; j < 6 && j < NJ; j++) begin
				for (int r = 0; r < 3; r++)
					d[r] = sat(longint'(tot[r][3]) - pj[j][r]);
				jac[0][j] = sat(longint'(qmul(zc[j][1], d[2])) - qmul(zc[j][2], d[1]));
				jac[1][j] = sat(longint'(qmul(zc[j][2], d[0])) - qmul(zc[j][0], d[2]));
				jac[2][j] = sat(longint'(qmul(zc[j][0], d[1])) - qmul(zc[j][1], d[0]));
				for (int r = 0; r < 3; r++)
					jac[3+r][j] = zc[j][r];
			end
			if (st.ident_z)
				for (int c = 0; c < 6; c++)
					for (int r = 0; r < 6; r++)
						jac[r][c] = (r == 5) ? ONE : 0;
			for (int r = 0; r < 6; r++)
				for (int c = 0; c < 6; c++)
					push_beat(K_JAC, r, c, jac[r][c]);
		end
		pending_beats[$].last = 1'b1;
	endfunction

	task automatic send_beat(stim_t st);
		while ($urandom_range(99) < s_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= st.func;
		s_tdata  <= {1'b0, st.value, st.element, st.joint};
		do @(posedge clk); while (!s_tready);
		predict_kinematics(st);
	endtask

	function automatic stim_t mk(func_t f, int j, int e, logic [31:0] v, bit idz = 1'b0);
		stim_t st;
		st.func    = f;
		st.joint   = j[2:0];
		st.element = e[3:0];
		st.value   = v;
		st.ident_z = idz;
		return st;
	endfunction

	function automatic stim_t rand_stim();
		int r;
		logic [31:0] v;
		r = $urandom_range(99);
		if ($urandom_range(1))
			v = $urandom;
		else
			v = $urandom_range(1 << 25) - (1 << 24);
		if (r < 10)
			return mk($urandom_range(1) ? F_JAC : F_POSE, $urandom_range(7),
				$urandom_range(15), v);
		if (r < 45)
			return mk(F_ANGLE, $urandom_range(7), $urandom_range(15), v);
		return mk(F_WORD, $urandom_range(7), $urandom_range(15), v);
	endfunction

	// receiver, checker and watchdog
	initial begin
		beat_t exp_b;
		m_tready  = 1'b0;
		hold_left = 0;
		quiet_cyc = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_beats.size() == 0) begin
					$display("%0t: unexpected beat row %0d col %0d entry %h", $time,
						m_tdata[2:0], m_tdata[5:3], m_tdata[37:6]);
					errors++;
				end else begin
					exp_b = pending_beats.pop_front();
					if (m_tuser !== exp_b.kind || m_tdata[2:0] !== exp_b.row ||
						m_tdata[5:3] !== exp_b.col || m_tdata[37:6] !== exp_b.entry ||
						m_tlast !== exp_b.last || m_tdata[39:38] !== 2'b00) begin
						$display("%0t: mismatch exp kind %0d row %0d col %0d entry %h last %0d",
							$time, exp_b.kind, exp_b.row, exp_b.col, exp_b.entry, exp_b.last);
						$display("%0t:          got kind %0d row %0d col %0d entry %h last %0d",
							$time, m_tuser, m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tlast);
						errors++;
					end
				end
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				quiet_cyc = 0;
			else
				quiet_cyc++;
			if (quiet_cyc >= WDOG_LIM) begin
				$display("TB_ERROR");
				$finish;
			end
			if (hold_go) begin
				hold_go   = 1'b0;
				hold_left = HOLD_CYC;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= ($urandom_range(99) >= m_stall);
		end
	end

	initial begin
		stim_t tbl [$];
		errors   = 0;
		s_idle   = 0;
		m_stall  = 0;
		hold_go  = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		foreach (arm_words[i]) arm_words[i] = 0;
		foreach (arm_angles[i]) arm_angles[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every model word written: identity origins, zero offsets, axes along z
		for (int j = 0; j < NJ; j++)
			for (int e = 0; e < NW; e++)
				send_beat(mk(F_WORD, j, e,
					(e == 0 || e == 4 || e == 8 || e == 14) ? ONE : 0));

		tbl = '{
			mk(F_POSE, 0, 0, 0, 1'b1),
			mk(F_JAC, 0, 0, 0, 1'b1),
			mk(F_ANGLE, 0, 0, 32'h7fffffff),
			mk(F_ANGLE, 1, 0, 32'h80000000),
			mk(F_ANGLE, 2, 0, 32'd52707179),
			mk(F_ANGLE, 3, 0, -32'sd52707179),
			mk(F_ANGLE, 4, 0, 32'd26353590),
			mk(F_ANGLE, 5, 15, -32'sd26353590),
			mk(F_JAC, 0, 0, 0, 1'b1),
			mk(F_ANGLE, 6, 0, 32'h12345678),
			mk(F_ANGLE, 7, 0, 32'hffffffff),
			mk(F_WORD, 7, 3, 32'h7fffffff),
			mk(F_WORD, 2, 15, 32'h80000000),
			mk(F_WORD, 0, 12, 32'd9876543),
			mk(F_WORD, 0, 13, 32'd13500000),
			mk(F_WORD, 0, 14, 32'd0),
			mk(F_WORD, 0, 9, 32'h7fffffff),
			mk(F_WORD, 1, 10, 32'h80000000),
			mk(F_WORD, 2, 0, 32'h7fffffff),
			mk(F_WORD, 3, 5, 32'h80000000),
			mk(F_JAC, 5, 14, 32'hffffffff),
			mk(F_POSE, 7, 15, 32'h00000000)
		};
		foreach (tbl[i])
			send_beat(tbl[i]);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin s_idle = 0;  m_stall = 0;  end
				1: begin s_idle = 70; m_stall = 0;  end
				2: begin s_idle = 0;  m_stall = 70; end
				default: begin s_idle = 37; m_stall = 37; end
			endcase
			if (ph == 0)
				hold_go = 1'b1;
			for (int n = 0; n < 50; n++)
				send_beat(rand_stim());
		end
		s_tvalid <= 1'b0;

		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// File: filelist.f
src/safk_pkg.sv
src/safk_cordic.sv
src/safk_dp.sv
src/safk_ctrl.sv
src/serial_arm_forward_kinematics.sv
tb/serial_arm_forward_kinematics_tb.sv
